/* rtl/textured_wall_column_pixel_top_assert.svh */
// Assertion macros for the textured wall column pixel block.
// Used by textured_wall_column_pixel_top; the macros sample on clk_i and reset with rst_ni.
`ifndef TEXTURED_WALL_COLUMN_PIXEL_TOP_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_PIXEL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold after the antecedent, with the delay given by the n argument.
`define TWCP_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

/* rtl/twcp_pkg.sv */
// Shared types and constants for the textured wall column pixel block.
// No dependencies; imported by textured_wall_column_pixel_top.
package twcp_pkg;

  localparam int X_W         = 10;
  localparam int Y_W         = 10;
  localparam int HEIGHT_W    = 16;
  localparam int SIDE_W      = 2;
  localparam int FRAC_W      = 16;
  localparam int COLOR_W     = 32;
  localparam int TEX_FIELD_W = 6;
  localparam int CFG_ADDR_W  = 1;

  localparam int SCREEN_HEIGHT_DEF  = 1024;
  localparam int TEX_SIZE_DEF       = 64;
  localparam int DIV_BITS_PER_STAGE = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_TOP_COLOR    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOTTOM_COLOR = 1'b1;

  typedef enum logic [1:0] {
    KIND_TOP    = 2'd0,
    KIND_WALL   = 2'd1,
    KIND_BOTTOM = 2'd2
  } pixel_kind_e;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_NORTH = 2'd0,
    SIDE_SOUTH = 2'd1,
    SIDE_EAST  = 2'd2,
    SIDE_WEST  = 2'd3
  } wall_side_e;

  typedef struct packed {
    logic [X_W-1:0]         x;
    logic [Y_W-1:0]         y;
    pixel_kind_e            kind;
    logic [COLOR_W-1:0]     color;
    logic [SIDE_W-1:0]      side;
    logic [TEX_FIELD_W-1:0] u;
  } pix_meta_t;

endpackage

/* rtl/textured_wall_column_pixel_top.sv */
// Textured wall column pixel classifier: classify, texel u, pipelined texel v divide.
// Depends on twcp_pkg and textured_wall_column_pixel_top_assert.svh.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  config  | cfg_we_i cfg_addr_i cfg_wdata_i                    | in
//  pixel   | start busy column_x_i row_y_i wall_height_i ...    | in (busy: out)
//  result  | result_valid_o pixel_x_o ... tex_u_o tex_v_o       | out
//
// One pixel is taken every cycle; busy is always low.
// Each pixel passes the classify register, the multiply register and then the restoring
// divider stages, which yield two quotient bits per stage.
// Reset clears the valid bits and both color registers.
// The pipeline never stalls, since the result side cannot hold results off.
`include "textured_wall_column_pixel_top_assert.svh"

module textured_wall_column_pixel_top import twcp_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int TEX_SIZE      = TEX_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [COLOR_W-1:0]     cfg_wdata_i,
  input  logic                   start,
  output logic                   busy,
  input  logic [X_W-1:0]         column_x_i,
  input  logic [Y_W-1:0]         row_y_i,
  input  logic [HEIGHT_W-1:0]    wall_height_i,
  input  logic [SIDE_W-1:0]      wall_side_i,
  input  logic [FRAC_W-1:0]      hit_fraction_i,
  output logic                   result_valid_o,
  output logic [X_W-1:0]         pixel_x_o,
  output logic [Y_W-1:0]         pixel_y_o,
  output logic [1:0]             pixel_kind_o,
  output logic [COLOR_W-1:0]     pixel_color_o,
  output logic [SIDE_W-1:0]      tex_select_o,
  output logic [TEX_FIELD_W-1:0] tex_u_o,
  output logic [TEX_FIELD_W-1:0] tex_v_o
);

  localparam int QW   = $clog2(TEX_SIZE);
  localparam int NW   = HEIGHT_W + QW;
  localparam int NDIV = (QW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int LAT  = NDIV + 2;
  localparam int HALF = SCREEN_HEIGHT / 2;
  localparam int SW   = $clog2(HALF + (1 << HEIGHT_W)) + 1;

  logic [COLOR_W-1:0] top_color_q, bottom_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_color_q    <= '0;
      bottom_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TOP_COLOR:    top_color_q    <= cfg_wdata_i;
        CFG_BOTTOM_COLOR: bottom_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                   accept;
  logic [HEIGHT_W-1:0]    h_ceil;
  logic [SW-1:0]          top_s, bottom_s, y_s, diff_s;
  logic                   above, in_wall;
  logic [NW-1:0]          u_prod;
  logic [QW-1:0]          u_raw, u_clamp, u_fin;
  logic [QW+TEX_FIELD_W-1:0] u_ext;
  pix_meta_t              meta_d;

  assign accept = start && !busy;

  always_comb begin
    h_ceil   = HEIGHT_W'(({1'b0, wall_height_i} + 17'd1) >> 1);
    top_s    = SW'(HALF) - SW'(h_ceil);
    bottom_s = SW'(HALF) + SW'(wall_height_i >> 1);
    y_s      = SW'(row_y_i);
    above    = $signed(y_s) < $signed(top_s);
    in_wall  = !above && ($signed(y_s) < $signed(bottom_s)) && (wall_height_i != '0);
    diff_s   = y_s - top_s - ((top_s[SW-1]) ? SW'(wall_height_i[0]) : SW'(0));

    u_prod  = NW'(hit_fraction_i) * NW'(TEX_SIZE);
    u_raw   = u_prod[NW-1:FRAC_W];
    u_clamp = (u_raw > QW'(TEX_SIZE - 1)) ? QW'(TEX_SIZE - 1) : u_raw;
    if (wall_side_i inside {SIDE_NORTH, SIDE_EAST}) begin
      u_fin = QW'(TEX_SIZE - 1) - u_clamp;
    end else begin
      u_fin = u_clamp;
    end
    u_ext = (QW + TEX_FIELD_W)'(u_fin);

    meta_d.x    = column_x_i;
    meta_d.y    = row_y_i;
    meta_d.side = wall_side_i;
    if (above) begin
      meta_d.kind  = KIND_TOP;
      meta_d.color = top_color_q;
      meta_d.u     = '0;
    end else if (in_wall) begin
      meta_d.kind  = KIND_WALL;
      meta_d.color = '0;
      meta_d.u     = u_ext[TEX_FIELD_W-1:0];
    end else begin
      meta_d.kind  = KIND_BOTTOM;
      meta_d.color = bottom_color_q;
      meta_d.u     = '0;
    end
  end

  logic                s0_valid_q;
  pix_meta_t           s0_meta_q;
  logic [HEIGHT_W-1:0] s0_d_q, s0_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_meta_q <= meta_d;
    s0_d_q    <= diff_s[HEIGHT_W-1:0];
    s0_h_q    <= wall_height_i;
  end

  logic [NDIV:0]       valid_q;
  pix_meta_t           meta_q [0:NDIV];
  logic [HEIGHT_W-1:0] div_q  [0:NDIV];
  logic [HEIGHT_W-1:0] rem_q  [0:NDIV];
  logic [QW-1:0]       low_q  [0:NDIV];
  logic [QW-1:0]       quo_q  [0:NDIV];
  logic [NW-1:0]       num;

  assign num = NW'(s0_d_q) * NW'(TEX_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= s0_meta_q;
    div_q[0]  <= s0_h_q;
    rem_q[0]  <= num[NW-1:QW];
    low_q[0]  <= num[QW-1:0];
    quo_q[0]  <= '0;
  end

  for (genvar s = 1; s <= NDIV; s++) begin : g_div
    logic [HEIGHT_W-1:0] r;
    logic [HEIGHT_W:0]   t;
    logic [QW-1:0]       l, q;

    always_comb begin
      r = rem_q[s-1];
      l = low_q[s-1];
      q = quo_q[s-1];
      t = '0;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        if ((s - 1) * DIV_BITS_PER_STAGE + b < QW) begin
          t = {r, l[QW-1]};
          l = l << 1;
          if (t >= {1'b0, div_q[s-1]}) begin
            t = t - {1'b0, div_q[s-1]};
            q = (q << 1) | QW'(1);
          end else begin
            q = q << 1;
          end
          r = t[HEIGHT_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      meta_q[s] <= meta_q[s-1];
      div_q[s]  <= div_q[s-1];
      rem_q[s]  <= r;
      low_q[s]  <= l;
      quo_q[s]  <= q;
    end
  end

  logic [QW+TEX_FIELD_W-1:0] v_ext;

  assign v_ext          = (QW + TEX_FIELD_W)'(quo_q[NDIV]);
  assign result_valid_o = valid_q[NDIV];
  assign pixel_x_o      = meta_q[NDIV].x;
  assign pixel_y_o      = meta_q[NDIV].y;
  assign pixel_kind_o   = meta_q[NDIV].kind;
  assign pixel_color_o  = meta_q[NDIV].color;
  assign tex_select_o   = meta_q[NDIV].side;
  assign tex_u_o        = meta_q[NDIV].u;
  assign tex_v_o        = (meta_q[NDIV].kind == KIND_WALL) ? v_ext[TEX_FIELD_W-1:0] : '0;

  `TWCP_ASSERT_DLY(a_latency_row, accept, LAT,
                   result_valid_o && pixel_y_o == $past(row_y_i, LAT))
  `TWCP_ASSERT_IMP(a_div_rem_bound, valid_q[NDIV] && meta_q[NDIV].kind == KIND_WALL,
                   rem_q[NDIV] < div_q[NDIV])
  `TWCP_ASSERT_IMP(a_wall_no_color, result_valid_o && pixel_kind_o == KIND_WALL,
                   pixel_color_o == '0)

endmodule
